FILE: src/moebius_table_sieve_core_defines.svh
// Assertion macros for the Moebius table sieve core.
// Included by the top level; uses its clock and reset names.
`ifndef MOEBIUS_TABLE_SIEVE_CORE_DEFINES_SVH
`define MOEBIUS_TABLE_SIEVE_CORE_DEFINES_SVH

// Same-cycle implication, checked on each rising edge out of reset
`define MTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on each rising edge out of reset
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mts_pkg.sv
// Shared types and constants for the Moebius table sieve core.
// No dependencies; imported by moebius_table_sieve_core.
package mts_pkg;

    // Default largest table index
    localparam int MAX_N_DEF = 65535;

    // Width of the limit register and the index field
    localparam int LIMIT_W = 16;

    // APB address width and register byte address
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_LIMIT = 3'd0;

    // Operation codes
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUILT     = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SQ,
        S_SQ_CHK,
        S_MUL_RD,
        S_MUL_WR,
        S_ZERO,
        S_FIN_RD,
        S_FIN_WR,
        S_DONE
    } t_state;

endpackage

FILE: src/moebius_table_sieve_core.sv
// Moebius function table: sieve build sequencer, table memory, read path.
// Depends on mts_pkg and moebius_table_sieve_core_defines.svh.
//
//   channel   direction  handshake                      payload
//   input     in         i_in_valid / o_in_stall        i_operation, i_index
//   result    out        o_out_valid / i_out_stall      o_value, o_status
//   config    in         APB psel/penable/pwrite        paddr, pwdata, prdata
//
// A read passes through the DONE state and then the output register,
// whether it is served or not. A build fills table entries 0 to
// top = min(limit, MAX_N) through the single table write port.
// Reset is synchronous, active low; the table contents are not cleared.
// A stalled result holds in the output register; the next item is taken
// meanwhile, and its result waits in the last state until the register frees.
`include "moebius_table_sieve_core_defines.svh"

module moebius_table_sieve_core #(
    parameter int MAX_N = mts_pkg::MAX_N_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [mts_pkg::LIMIT_W-1:0] i_index,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [1:0]           o_value,
    output logic [1:0]                  o_status,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mts_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mts_pkg::*;

    // Table address width, working product width, counter width
    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N + 1) : 1;
    localparam int SW = AW + 2;
    localparam int XW = ((AW > LIMIT_W) ? AW : LIMIT_W) + 1;
    localparam int EW = ((SW > XW + 1) ? SW : XW + 1) + 1;
    localparam int DEPTH = MAX_N + 1;

    localparam logic signed [SW-1:0] MU_ONE  = SW'(1);
    localparam logic signed [SW-1:0] MU_NEG  = -SW'(1);
    localparam logic signed [SW-1:0] MU_ZERO = '0;

    // Control registers
    t_state            r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic              r_built;
    logic [XW-1:0]     r_built_limit;
    logic [XW-1:0]     r_top;
    logic [XW-1:0]     r_i;
    logic [XW-1:0]     r_j;
    logic [XW-1:0]     r_sq;
    logic [1:0]        r_status;
    logic              r_out_valid;
    logic signed [1:0] r_value;
    logic [1:0]        r_out_status;

    // Table memory
    logic signed [SW-1:0] r_mem [DEPTH];
    logic signed [SW-1:0] r_rd_data;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_cfg_wr;
    logic [XW-1:0]        w_top_clamp;
    logic [XW-1:0]        w_idx_ext;
    logic                 w_rd_ok;
    logic [XW-1:0]        w_j_step;
    logic [XW-1:0]        w_j_sq;
    logic                 w_build_end;

    logic                 w_mem_we;
    logic                 w_mem_re;
    logic [XW-1:0]        w_rd_addr;
    logic signed [SW-1:0] w_wr_data;

    logic signed [SW-1:0] w_mul_a;
    logic signed [XW:0]   w_mul_b;
    logic signed [SW+XW:0] w_mul_p;

    logic signed [EW-1:0] w_p_ext;
    logic signed [EW-1:0] w_n_ext;
    logic signed [SW-1:0] w_mu;

    // Handshake and decode
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign w_top_clamp = (XW'(r_limit) > XW'(MAX_N)) ? XW'(MAX_N) : XW'(r_limit);
    assign w_idx_ext   = XW'(i_index);
    assign w_rd_ok     = r_built && (w_idx_ext <= r_built_limit);
    assign w_j_step    = r_j + r_i;
    assign w_j_sq      = r_j + r_sq;

    // Shared multiplier: i*i when probing, product*(-i) when marking
    assign w_mul_p = w_mul_a * w_mul_b;

    // Final sign mapping of a working product
    assign w_p_ext = EW'(r_rd_data);
    assign w_n_ext = EW'($signed({1'b0, r_j}));
    always_comb begin
        priority if (w_p_ext == w_n_ext) begin
            w_mu = MU_ONE;
        end else if (w_p_ext + w_n_ext == '0) begin
            w_mu = MU_NEG;
        end else if (w_p_ext < 0) begin
            w_mu = MU_ONE;
        end else if (w_p_ext > 0) begin
            w_mu = MU_NEG;
        end else begin
            w_mu = MU_ZERO;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_operation == OP_BUILD) ? S_INIT : S_DONE;
                end
            end
            S_INIT: begin
                if (r_j == r_top) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_SQ_CHK;
            end
            S_SQ_CHK: begin
                priority if (r_sq > r_top) begin
                    if (r_top < XW'(2)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIN_RD;
                    end
                end else if (r_rd_data != MU_ONE) begin
                    n_state = S_SQ;
                end else begin
                    n_state = S_MUL_RD;
                end
            end
            S_MUL_RD: begin
                n_state = S_MUL_WR;
            end
            S_MUL_WR: begin
                n_state = (w_j_step > r_top) ? S_ZERO : S_MUL_RD;
            end
            S_ZERO: begin
                if (w_j_sq > r_top) begin
                    n_state = S_SQ;
                end
            end
            S_FIN_RD: begin
                n_state = S_FIN_WR;
            end
            S_FIN_WR: begin
                if (r_j == r_top) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port, multiplier operand selection and build completion
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_rd_addr   = r_j;
        w_wr_data   = MU_ONE;
        w_mul_a     = r_rd_data;
        w_mul_b     = -$signed({1'b0, r_i});
        w_build_end = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_rd_addr = w_idx_ext;
                w_mem_re  = w_in_acc && (i_operation == OP_READ) && w_rd_ok;
            end
            S_INIT: begin
                w_mem_we  = 1'b1;
                w_wr_data = MU_ONE;
            end
            S_SQ: begin
                w_rd_addr = r_i;
                w_mem_re  = 1'b1;
                w_mul_a   = $signed(SW'(r_i));
                w_mul_b   = $signed({1'b0, r_i});
            end
            S_MUL_RD, S_FIN_RD: begin
                w_mem_re = 1'b1;
            end
            S_MUL_WR: begin
                w_mem_we  = 1'b1;
                w_wr_data = w_mul_p[SW-1:0];
            end
            S_ZERO: begin
                w_mem_we  = 1'b1;
                w_wr_data = MU_ZERO;
            end
            S_FIN_WR: begin
                w_mem_we    = 1'b1;
                w_wr_data   = w_mu;
                w_build_end = (r_j == r_top);
            end
            S_SQ_CHK: begin
                w_build_end = (r_sq > r_top) && (r_top < XW'(2));
            end
            S_DONE: begin
                w_mem_re = 1'b0;
            end
            default: w_mem_re = 1'b0;
        endcase
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_j[AW-1:0]] <= w_wr_data;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_rd_addr[AW-1:0]];
        end
    end

    // Sequencer state and build flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_build_end) begin
                r_built <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_build_end) begin
            r_built_limit <= r_top;
        end
    end

    // Loop counters
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_top    <= w_top_clamp;
                    r_j      <= '0;
                    if (i_operation == OP_BUILD) begin
                        r_status <= ST_BUILT;
                    end else begin
                        r_status <= w_rd_ok ? ST_OK : ST_NOT_READY;
                    end
                end
            end
            S_INIT: begin
                r_j <= r_j + XW'(1);
                r_i <= XW'(2);
            end
            S_SQ: begin
                r_sq <= w_mul_p[XW-1:0];
            end
            S_SQ_CHK: begin
                priority if (r_sq > r_top) begin
                    r_j <= XW'(2);
                end else if (r_rd_data != MU_ONE) begin
                    r_i <= r_i + XW'(1);
                end else begin
                    r_j <= r_i;
                end
            end
            S_MUL_WR: begin
                r_j <= (w_j_step > r_top) ? r_sq : w_j_step;
            end
            S_ZERO: begin
                r_j <= w_j_sq;
                if (w_j_sq > r_top) begin
                    r_i <= r_i + XW'(1);
                end
            end
            S_FIN_WR: begin
                r_j <= r_j + XW'(1);
            end
            S_MUL_RD, S_FIN_RD, S_DONE: begin
                r_i <= r_i;
            end
            default: r_i <= r_i;
        endcase
    end

    // Output register: load on leaving DONE, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_status <= r_status;
            r_value      <= (r_status == ST_OK) ? r_rd_data[1:0] : 2'sd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_out_status;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(65535);
        end else if (w_cfg_wr && paddr == ADDR_LIMIT) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LIMIT) ? 32'(r_limit) : '0;

    // Checks
    `MTS_ASSERT_NOW(a_ok_needs_built, o_out_valid && o_status == ST_OK, r_built, "read ok before build")
    `MTS_ASSERT_NOW(a_wr_in_range, w_mem_we, r_j <= r_top, "table write beyond build range")
    `MTS_ASSERT_NEXT(a_build_starts, w_in_acc && i_operation == OP_BUILD, r_state == S_INIT, "build did not start")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for moebius_table_sieve_core: a directed table of builds and reads,
// then random segments checked against a sieve predictor. Depends on mts_pkg and the core.
module tb;
    import mts_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENTS      = 5;
    localparam int READS_PER_SEG = 64;
    localparam int TAIL_CYCLES   = 8;

    typedef struct packed {
        logic [1:0] value;
        logic [1:0] status;
    } t_mu_result;

    typedef enum logic {ROW_ITEM, ROW_LIMIT} t_row_kind;

    // arg is the index of an item row, or the limit of a register row
    typedef struct packed {
        t_row_kind   kind;
        logic        op;
        logic [15:0] arg;
        logic        typed;
        t_mu_result  want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_operation;
    logic [LIMIT_W-1:0]  i_index;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic signed [1:0]   o_value;
    logic [1:0]          o_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    int          mu_table [0:MAX_N_DEF];
    bit          tbl_built = 1'b0;
    int          built_top = 0;
    logic [15:0] limit_reg = 16'hFFFF;
    t_mu_result  mu_expect [$];
    t_dir_row    dir_rows [$];

    int   err_cnt = 0;
    int   cycle_cnt = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req = 1'b0;
    int   hold_cnt = 0;

    moebius_table_sieve_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_status    (o_status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        $display("MISMATCH %s: got %0d, expected %0d, cycle %0d", what, got, want,
                 cycle_cnt);
    endtask

    // Sieve the working products up to top, then fold each product to mu(n)
    function automatic void fill_mobius(input int top);
        int p;
        for (int n = 0; n <= top; n++)
            mu_table[n] = 1;
        for (int i = 2; i * i <= top; i++) begin
            if (mu_table[i] == 1) begin
                for (int j = i; j <= top; j += i)
                    mu_table[j] = mu_table[j] * -i;
                for (int j = i * i; j <= top; j += i * i)
                    mu_table[j] = 0;
            end
        end
        for (int n = 2; n <= top; n++) begin
            p = mu_table[n];
            if (p == n)
                mu_table[n] = 1;
            else if (p == -n)
                mu_table[n] = -1;
            else if (p < 0)
                mu_table[n] = 1;
            else if (p > 0)
                mu_table[n] = -1;
        end
    endfunction

    // Update the table state for one transfer and return its result
    function automatic t_mu_result predict_mobius(input logic op, input logic [15:0] idx);
        t_mu_result r;
        int         m;
        r = '0;
        if (op == OP_BUILD) begin
            // saturate to the table size
            built_top = (limit_reg > MAX_N_DEF) ? MAX_N_DEF : limit_reg;
            fill_mobius(built_top);
            tbl_built = 1'b1;
            r.status = ST_BUILT;
        end else if (!tbl_built || idx > built_top) begin
            r.status = ST_NOT_READY;
        end else begin
            m = mu_table[idx];
            r.value = m[1:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic void dir_item(input logic op, input logic [15:0] idx, input logic typed,
                                     input logic [1:0] value, input logic [1:0] status);
        t_dir_row row;
        row.kind = ROW_ITEM;
        row.op = op;
        row.arg = idx;
        row.typed = typed;
        row.want.value = value;
        row.want.status = status;
        dir_rows.push_back(row);
    endfunction

    function automatic void dir_limit(input logic [15:0] lim);
        t_dir_row row;
        row = '0;
        row.kind = ROW_LIMIT;
        row.arg = lim;
        dir_rows.push_back(row);
    endfunction

    // Mostly inside the built range, some at its edge, the rest anywhere
    function automatic logic [15:0] read_index();
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (r < 70)
            idx = $urandom_range(0, built_top);
        else if (r < 85)
            idx = built_top + $urandom_range(0, 3);
        else
            idx = $urandom_range(0, 65535);
        if (idx > 65535)
            idx = 65535;
        return idx[15:0];
    endfunction

    // Offer one item, optionally after a gap; queue its result once transferred
    task automatic send_item(input logic op, input logic [15:0] idx, input logic typed,
                             input t_mu_result want);
        t_mu_result pred;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_index     <= idx;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_mobius(op, idx);
        mu_expect.push_back(typed ? want : pred);
    endtask

    // Drop valid and wait for every queued result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (mu_expect.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the limit register, then read it back
    task automatic write_limit(input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LIMIT;
        pwdata  <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_reg = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'h0000, val})
            report_mismatch("limit read-back", int'(prdata), int'(val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stall the result side: one long hold-off on request, else random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Compare each transferred result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_mu_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mu_expect.size() == 0) begin
                report_mismatch("result with nothing expected, status", int'(o_status), -1);
            end else begin
                want = mu_expect.pop_front();
                if (o_value !== want.value)
                    report_mismatch("value", int'(o_value), int'($signed(want.value)));
                if (o_status !== want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_mu_result  none;
        logic [15:0] lim;
        bit          must_build;
        none = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_BUILD;
        i_index     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = ADDR_LIMIT;
        pwdata      = '0;
        tx_idle_pct = 11;
        rx_idle_pct = 62;

        // reads before any build, then tables built to 0, 1 and 100, then a limit change without rebuild
        dir_item(OP_READ, 16'd0, 1'b1, 2'b00, ST_NOT_READY);
        dir_item(OP_READ, 16'hFFFF, 1'b1, 2'b00, ST_NOT_READY);
        dir_limit(16'd0);
        dir_item(OP_BUILD, 16'hFFFF, 1'b1, 2'b00, ST_BUILT);
        dir_item(OP_READ, 16'd0, 1'b1, 2'b01, ST_OK);
        dir_item(OP_READ, 16'd1, 1'b1, 2'b00, ST_NOT_READY);
        dir_limit(16'd1);
        dir_item(OP_BUILD, 16'd0, 1'b1, 2'b00, ST_BUILT);
        dir_item(OP_READ, 16'd1, 1'b1, 2'b01, ST_OK);
        dir_item(OP_READ, 16'd2, 1'b1, 2'b00, ST_NOT_READY);
        dir_limit(16'd100);
        dir_item(OP_READ, 16'd50, 1'b1, 2'b00, ST_NOT_READY);
        dir_item(OP_BUILD, 16'd0, 1'b1, 2'b00, ST_BUILT);
        dir_item(OP_READ, 16'd2, 1'b0, 2'b00, ST_OK);
        dir_item(OP_READ, 16'd4, 1'b0, 2'b00, ST_OK);
        dir_item(OP_READ, 16'd6, 1'b0, 2'b00, ST_OK);
        dir_item(OP_READ, 16'd30, 1'b0, 2'b00, ST_OK);
        dir_item(OP_READ, 16'd97, 1'b0, 2'b00, ST_OK);
        dir_item(OP_READ, 16'd100, 1'b0, 2'b00, ST_OK);
        dir_item(OP_READ, 16'd101, 1'b1, 2'b00, ST_NOT_READY);
        dir_limit(16'd30);
        dir_item(OP_READ, 16'd100, 1'b0, 2'b00, ST_OK);
        dir_item(OP_READ, 16'd101, 1'b1, 2'b00, ST_NOT_READY);
        dir_item(OP_READ, 16'hFFFF, 1'b1, 2'b00, ST_NOT_READY);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        for (int k = 0; k < dir_rows.size(); k++) begin
            if (dir_rows[k].kind == ROW_LIMIT) begin
                drain_results();
                write_limit(dir_rows[k].arg);
            end else begin
                send_item(dir_rows[k].op, dir_rows[k].arg, dir_rows[k].typed,
                          dir_rows[k].want);
            end
        end

        // random segments: slow receiver, then slow sender, then no idling
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 62 : 0;
            rx_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 11 : 0;
            for (int sg = 0; sg < SEGMENTS; sg++) begin
                drain_results();
                must_build = 1'b0;
                if (ph == 2 && sg == SEGMENTS - 1) begin
                    // the one full-size table
                    lim = 16'hFFFF;
                    must_build = 1'b1;
                end else if (ph == 1 && sg == 2) begin
                    lim = 16'($urandom_range(4000, 9000));
                    must_build = 1'b1;
                end else if ($urandom_range(0, 9) < 7) begin
                    lim = 16'($urandom_range(2, 1200));
                end else begin
                    lim = 16'($urandom_range(0, 40));
                end
                write_limit(lim);
                // now and then keep reading the old table under the new limit
                if (must_build || $urandom_range(0, 3) != 0)
                    send_item(OP_BUILD, 16'($urandom_range(0, 65535)), 1'b0, none);
                // hold the result side off while reads keep coming
                if (ph == 2 && sg == 0)
                    hold_req <= 1'b1;
                for (int n = 0; n < READS_PER_SEG; n++) begin
                    if (limit_reg <= 2000 && $urandom_range(0, 99) < 3)
                        send_item(OP_BUILD, 16'($urandom_range(0, 65535)), 1'b0, none);
                    else
                        send_item(OP_READ, read_index(), 1'b0, none);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/mts_pkg.sv
src/moebius_table_sieve_core.sv
dv/tb.sv
